/* rtl/cdc_pkg.sv */
package cdc_pkg;

   // Graph size and field widths
   localparam int MAX_VERTICES = 16;
   localparam int COLOR_BITS   = 2;
   localparam int VERTEX_BITS  = $clog2(MAX_VERTICES);
   localparam int VCOUNT_BITS  = $clog2(MAX_VERTICES + 1);
   localparam int COUNT_BITS   = 4;
   localparam int KIND_BITS    = 2;
   localparam int EDGE_DEPTH   = MAX_VERTICES * (MAX_VERTICES - 1) / 2;
   localparam int ADDR_BITS    = $clog2(EDGE_DEPTH);

   localparam logic [VCOUNT_BITS-1:0] VCOUNT_RESET = VCOUNT_BITS'(MAX_VERTICES);

   // Item kinds
   localparam logic [KIND_BITS-1:0] KIND_WRITE = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_FILL  = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_ONE   = 2'd2;
   localparam logic [KIND_BITS-1:0] KIND_ALL   = 2'd3;

   typedef struct packed {
      logic [KIND_BITS-1:0]   kind;
      logic [VERTEX_BITS-1:0] vertex_a;
      logic [VERTEX_BITS-1:0] vertex_b;
      logic [COLOR_BITS-1:0]  color;
   } req_payload_type;

   typedef struct packed {
      logic [VERTEX_BITS-1:0] vertex;
      logic [COUNT_BITS-1:0]  count;
      logic                   last;
   } rsp_payload_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic write_edge;
      logic fill_step;
      logic scan_step;
      logic emit;
      logic next_vertex;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic                 vertex_bad;
      logic                 scan_last;
      logic                 fill_last;
      logic                 vertex_last;
      logic                 out_free;
   } status_type;

endpackage

/* rtl/cdc_datapath.sv */
module cdc_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  cdc_pkg::req_payload_type     req_payload,
   input  logic                         csr_write,
   input  logic [cdc_pkg::VCOUNT_BITS-1:0] csr_data,
   input  cdc_pkg::cmd_type             cmd,
   output cdc_pkg::status_type          status,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output cdc_pkg::rsp_payload_type     rsp_payload
);
   import cdc_pkg::*;

   // Triangular address of the edge between two distinct vertices
   function automatic logic [ADDR_BITS-1:0] edge_addr(
      input logic [VERTEX_BITS-1:0] a,
      input logic [VERTEX_BITS-1:0] b
   );
      logic [VERTEX_BITS-1:0]   hi;
      logic [VERTEX_BITS-1:0]   lo;
      logic [2*VERTEX_BITS-1:0] prod;
      logic [2*VERTEX_BITS-1:0] sum;
      hi   = (a > b) ? a : b;
      lo   = (a > b) ? b : a;
      prod = {{VERTEX_BITS{1'b0}}, hi} * {{VERTEX_BITS{1'b0}}, hi - 1'b1};
      sum  = (prod >> 1) + {{VERTEX_BITS{1'b0}}, lo};
      return sum[ADDR_BITS-1:0];
   endfunction

   logic [COLOR_BITS-1:0]  edge_mem_ff [EDGE_DEPTH];
   logic [COLOR_BITS-1:0]  mem_q_ff;

   logic [VCOUNT_BITS-1:0] vcount_ff, vcount_in;
   logic [KIND_BITS-1:0]   kind_ff, kind_in;
   logic [VERTEX_BITS-1:0] vert_a_ff, vert_a_in;
   logic [VERTEX_BITS-1:0] vert_b_ff, vert_b_in;
   logic [COLOR_BITS-1:0]  color_ff, color_in;
   logic [VERTEX_BITS-1:0] vertex_ff, vertex_in;
   logic [VCOUNT_BITS-1:0] scan_ff, scan_in;
   logic [COUNT_BITS-1:0]  acc_ff, acc_in;
   logic [ADDR_BITS-1:0]   fill_ff, fill_in;
   logic                   pend_ff, pend_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type        rsp_ff, rsp_in;

   logic [VCOUNT_BITS-1:0]   n_used;
   logic [VCOUNT_BITS-1:0]   n_m1;
   logic [2*VCOUNT_BITS-1:0] pair_prod;
   logic [ADDR_BITS-1:0]     fill_end;
   logic                     write_ok;
   logic                     mem_we;
   logic [ADDR_BITS-1:0]     mem_waddr;
   logic                     mem_re;
   logic [ADDR_BITS-1:0]     mem_raddr;
   logic                     vertex_last;

   // Clamp the vertex count to the supported range
   always_comb begin
      if (vcount_ff < VCOUNT_BITS'(2)) begin
         n_used = VCOUNT_BITS'(2);
      end else if (vcount_ff > VCOUNT_BITS'(MAX_VERTICES)) begin
         n_used = VCOUNT_BITS'(MAX_VERTICES);
      end else begin
         n_used = vcount_ff;
      end
   end

   assign n_m1      = n_used - 1'b1;
   assign pair_prod = {{VCOUNT_BITS{1'b0}}, n_used} * {{VCOUNT_BITS{1'b0}}, n_m1};
   assign fill_end  = ADDR_BITS'((pair_prod >> 1) - 1'b1);

   assign write_ok = (vert_a_ff != vert_b_ff)
                   && ({1'b0, vert_a_ff} < n_used)
                   && ({1'b0, vert_b_ff} < n_used);

   // Share the write port between edge writes and the fill sweep
   assign mem_we    = (cmd.write_edge && write_ok) || cmd.fill_step;
   assign mem_waddr = cmd.fill_step ? fill_ff : edge_addr(vert_a_ff, vert_b_ff);

   // Skip the diagonal while scanning
   assign mem_re    = cmd.scan_step && (scan_ff != {1'b0, vertex_ff});
   assign mem_raddr = edge_addr(vertex_ff, scan_ff[VERTEX_BITS-1:0]);

   assign vertex_last = ({1'b0, vertex_ff} == n_m1);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         edge_mem_ff[mem_waddr] <= color_ff;
      end
      if (mem_re) begin
         mem_q_ff <= edge_mem_ff[mem_raddr];
      end
   end

   // Next-state logic for item, scan and output registers
   always_comb begin
      vcount_in    = vcount_ff;
      kind_in      = kind_ff;
      vert_a_in    = vert_a_ff;
      vert_b_in    = vert_b_ff;
      color_in     = color_ff;
      vertex_in    = vertex_ff;
      scan_in      = scan_ff;
      acc_in       = acc_ff;
      fill_in      = fill_ff;
      pend_in      = mem_re;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (csr_write) begin
         vcount_in = csr_data;
      end

      // Count a matching edge in the cycle after its read
      if (pend_ff && (mem_q_ff == color_ff)) begin
         acc_in = acc_ff + 1'b1;
      end

      if (cmd.load) begin
         kind_in   = req_payload.kind;
         vert_a_in = req_payload.vertex_a;
         vert_b_in = req_payload.vertex_b;
         color_in  = req_payload.color;
         vertex_in = (req_payload.kind == KIND_ALL) ? '0 : req_payload.vertex_a;
         scan_in   = '0;
         acc_in    = '0;
         fill_in   = '0;
      end

      if (cmd.fill_step) begin
         fill_in = fill_ff + 1'b1;
      end

      if (cmd.scan_step) begin
         scan_in = scan_ff + 1'b1;
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_in.vertex = vertex_ff;
         rsp_in.count  = acc_ff;
         rsp_in.last   = (kind_ff == KIND_ONE) || vertex_last;
      end

      if (cmd.next_vertex) begin
         vertex_in = vertex_ff + 1'b1;
         scan_in   = '0;
         acc_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff    <= VCOUNT_RESET;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vcount_ff    <= vcount_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      vert_a_ff <= vert_a_in;
      vert_b_ff <= vert_b_in;
      color_ff  <= color_in;
      vertex_ff <= vertex_in;
      scan_ff   <= scan_in;
      acc_ff    <= acc_in;
      fill_ff   <= fill_in;
      rsp_ff    <= rsp_in;
   end

   // Report to the controller
   assign status.kind        = kind_ff;
   assign status.vertex_bad  = ({1'b0, vertex_ff} >= n_used);
   assign status.scan_last   = (scan_ff == n_m1);
   assign status.fill_last   = (fill_ff == fill_end);
   assign status.vertex_last = vertex_last;
   assign status.out_free    = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* rtl/cdc_ctrl.sv */
module cdc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  cdc_pkg::status_type status,
   output cdc_pkg::cmd_type    cmd
);
   import cdc_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_WRITE = 3'd1;
   localparam logic [2:0] ST_FILL  = 3'd2;
   localparam logic [2:0] ST_SCAN  = 3'd3;
   localparam logic [2:0] ST_DRAIN = 3'd4;
   localparam logic [2:0] ST_EMIT  = 3'd5;

   logic [2:0] state_ff, state_in;

   // Sequence one item at a time
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_WRITE: begin
            cmd.write_edge = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_FILL: begin
            cmd.fill_step = 1'b1;
            if (status.fill_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            // Route the loaded item by its kind; a query scans its vertex here
            if (status.kind == KIND_WRITE) begin
               cmd.write_edge = 1'b1;
               state_in       = ST_IDLE;
            end else if (status.kind == KIND_FILL) begin
               state_in = ST_FILL;
            end else if (status.vertex_bad) begin
               state_in = ST_EMIT;
            end else begin
               cmd.scan_step = 1'b1;
               if (status.scan_last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.kind == KIND_ALL && !status.vertex_last) begin
                  cmd.next_vertex = 1'b1;
                  state_in        = ST_SCAN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

/* rtl/colored_degree_counter.sv */
// Colored degree counter: edge colors of a complete graph on up to 16 vertices.
// Input channel req_*: one item per handshake (valid high, stall low). Kinds:
// write one edge, fill every edge in use, count a color at one vertex, or count
// it at every vertex. Result channel rsp_*: vertex, count and last; a query of
// one vertex gives one result, a full query gives one per vertex in use.
// Config port csr_*: vertex_count, always ready; write it only while idle.
// Items are handled one at a time; req_stall is high while one is at work.
// With n vertices in use, an edge write is loaded and then stored; a fill
// writes the n(n-1)/2 store entries in use, one store entry a cycle; a
// one-vertex query scans the n slots of its vertex through the single store
// read port, drains the last read and emits (a vertex out of range goes
// straight to emit); a full query does this for each vertex in turn.
// A finished result sits in an output register, so the next item is accepted
// while it waits; a stalled result holds and stops further results.
// Reset sets vertex_count to 16 and empties the output register. The edge
// store is not cleared: read only edges written since reset.
module colored_degree_counter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  cdc_pkg::req_payload_type          req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output cdc_pkg::rsp_payload_type          rsp_payload,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cdc_pkg::VCOUNT_BITS-1:0]   csr_data
);
   import cdc_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   cdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   cdc_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_write   (csr_valid && csr_ready),
      .csr_data    (csr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // Never load a result over one still waiting
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("result loaded over a waiting result");

   // One item at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second item accepted while busy");

   // Store port used by one operation per cycle
   a_port_excl: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.write_edge, cmd.fill_step, cmd.scan_step, cmd.load}))
      else $error("conflicting store commands");

   // A new result only after an accepted query
   a_rsp_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.emit))
      else $error("result without emit");

endmodule
